// File: hw/rtl/ils_pkg.sv
package ils_pkg;

  // default sizes of the store
  localparam int DEPTH_DEFAULT      = 1024;
  localparam int DATA_WIDTH_DEFAULT = 32;

  // fixed field widths
  localparam int POS_W   = 10;
  localparam int CAP_W   = 11;
  localparam int COUNT_W = 11;
  localparam int VALUE_W = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

  // depth of the queue between front and back
  localparam int QDEPTH = 2;

  typedef enum logic [2:0] {
    CMD_PUSH   = 3'd0,
    CMD_POP    = 3'd1,
    CMD_INSERT = 3'd2,
    CMD_ERASE  = 3'd3,
    CMD_FIND   = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_e;

  // work the back end has to do for one command
  typedef enum logic [2:0] {
    OP_NONE,    // report only, count unchanged
    OP_POP,     // report only, count - 1
    OP_PUSH,    // write at old count
    OP_INSERT,  // shift up, then write at position
    OP_ERASE,   // move last entry into position
    OP_FIND     // linear scan
  } op_kind_e;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_WRITE,
    BS_SHIFT,
    BS_MOVE_RD,
    BS_MOVE_WR,
    BS_SCAN,
    BS_REPORT
  } back_state_e;

  typedef struct packed {
    logic [2:0]               cmd;
    logic [POS_W-1:0]         position;
    logic signed [VALUE_W-1:0] value;
  } ils_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic               found;
    logic [POS_W-1:0]   found_index;
    logic [COUNT_W-1:0] entry_count_out;
  } ils_out_t;

  // classification handed from front to back
  typedef struct packed {
    op_kind_e kind;
    status_e  status;
  } op_ctl_t;

endpackage

// File: hw/rtl/ils_front.sv
module ils_front #(
  parameter int DEPTH = ils_pkg::DEPTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  ils_pkg::ils_in_t             item,
  output logic                         busy,
  input  logic                         cfg_we,
  input  logic [ils_pkg::CAP_W-1:0]    cfg_wdata,
  input  logic                         q_full,
  output logic                         q_push,
  output ils_pkg::op_ctl_t             op_ctl,
  output ils_pkg::ils_in_t             op_item,
  output logic [$clog2(DEPTH+1)-1:0]   op_count
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > ils_pkg::CAP_W) ? CW : ils_pkg::CAP_W;

  logic [ils_pkg::CAP_W-1:0] capacity_limit;
  logic [CW-1:0]             entry_count;
  logic [CW-1:0]             entry_count_next;

  logic [XW-1:0] pos_x;
  logic [XW-1:0] cnt_x;
  logic [XW-1:0] cap_x;
  logic          accept;

  assign busy   = q_full;
  assign accept = start && !busy;
  assign q_push = accept;

  // compare everything at one common width
  assign pos_x = XW'(item.position);
  assign cnt_x = XW'(entry_count);
  assign cap_x = (XW'(capacity_limit) > XW'(DEPTH)) ? XW'(DEPTH) : XW'(capacity_limit);

  // classify the beat against the count as it stands after all queued work
  always_comb begin
    op_ctl.kind      = ils_pkg::OP_NONE;
    op_ctl.status    = ils_pkg::ST_OK;
    entry_count_next = entry_count;
    unique case (item.cmd)
      ils_pkg::CMD_PUSH: begin
        if (cnt_x >= cap_x) begin
          op_ctl.status = ils_pkg::ST_FULL;
        end else begin
          op_ctl.kind      = ils_pkg::OP_PUSH;
          entry_count_next = entry_count + CW'(1);
        end
      end
      ils_pkg::CMD_POP: begin
        if (entry_count == '0) begin
          op_ctl.status = ils_pkg::ST_EMPTY;
        end else begin
          op_ctl.kind      = ils_pkg::OP_POP;
          entry_count_next = entry_count - CW'(1);
        end
      end
      ils_pkg::CMD_INSERT: begin
        if (pos_x > cnt_x) begin
          op_ctl.status = ils_pkg::ST_BADPOS;
        end else if (cnt_x >= cap_x) begin
          op_ctl.status = ils_pkg::ST_FULL;
        end else begin
          op_ctl.kind      = ils_pkg::OP_INSERT;
          entry_count_next = entry_count + CW'(1);
        end
      end
      ils_pkg::CMD_ERASE: begin
        if (entry_count == '0) begin
          op_ctl.status = ils_pkg::ST_EMPTY;
        end else if (pos_x >= cnt_x) begin
          op_ctl.status = ils_pkg::ST_BADPOS;
        end else begin
          op_ctl.kind      = ils_pkg::OP_ERASE;
          entry_count_next = entry_count - CW'(1);
        end
      end
      ils_pkg::CMD_FIND: begin
        op_ctl.kind = ils_pkg::OP_FIND;
      end
      default: begin
        op_ctl.kind = ils_pkg::OP_NONE;
      end
    endcase
  end

  assign op_item  = item;
  assign op_count = entry_count;

  // count and capacity registers
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= ils_pkg::CAP_RESET;
      entry_count    <= '0;
    end else begin
      if (cfg_we) begin
        capacity_limit <= cfg_wdata;
      end
      if (accept) begin
        entry_count <= entry_count_next;
      end
    end
  end

endmodule

// File: hw/rtl/ils_queue.sv
module ils_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int PW = $clog2(ils_pkg::QDEPTH);
  localparam int NW = $clog2(ils_pkg::QDEPTH + 1);

  logic [WIDTH-1:0] entries [ils_pkg::QDEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [NW-1:0]    fill;

  assign full  = (fill == NW'(ils_pkg::QDEPTH));
  assign empty = (fill == '0);
  assign rdata = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push && !full) begin
      entries[wr_ptr] <= wdata;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PW'(ils_pkg::QDEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == PW'(ils_pkg::QDEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      fill <= fill + NW'(push && !full) - NW'(pop && !empty);
    end
  end

endmodule

// File: hw/rtl/ils_back.sv
module ils_back #(
  parameter int DEPTH      = ils_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = ils_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_empty,
  output logic                         q_pop,
  input  ils_pkg::op_ctl_t             q_ctl,
  input  ils_pkg::ils_in_t             q_item,
  input  logic [$clog2(DEPTH+1)-1:0]   q_count,
  output logic                         done,
  output ils_pkg::ils_out_t            result
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  ils_pkg::back_state_e state, state_next;

  // latched command
  ils_pkg::op_kind_e kind, kind_next;
  ils_pkg::status_e  status_r, status_r_next;
  ils_pkg::ils_in_t  item_r, item_r_next;
  logic [CW-1:0]     cnt_r, cnt_r_next;

  // shift and scan bookkeeping
  logic [AW-1:0] dst, dst_next;
  logic          pend, pend_next;
  logic [AW-1:0] pend_dst, pend_dst_next;
  logic [CW-1:0] rd_idx, rd_idx_next;
  logic          cmp_valid, cmp_valid_next;
  logic [AW-1:0] cmp_idx, cmp_idx_next;
  logic          found_r, found_r_next;
  logic [AW-1:0] fidx_r, fidx_r_next;

  // memory port
  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;
  logic [DATA_WIDTH-1:0] rd_data;

  logic [DATA_WIDTH-1:0] val_w;
  logic [AW-1:0]         pos_a;
  logic [AW-1:0]         last_idx;
  logic                  match;
  logic [CW-1:0]         cnt_after;

  assign val_w    = DATA_WIDTH'(item_r.value);
  assign pos_a    = AW'(item_r.position);
  assign last_idx = AW'(cnt_r - CW'(1));
  assign match    = cmp_valid && (rd_data == val_w);

  // store with one write port and one read port, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ils_pkg::BS_IDLE: begin
        if (!q_empty) begin
          unique case (q_ctl.kind)
            ils_pkg::OP_PUSH:   state_next = ils_pkg::BS_WRITE;
            ils_pkg::OP_INSERT: state_next = ils_pkg::BS_SHIFT;
            ils_pkg::OP_ERASE:  state_next = ils_pkg::BS_MOVE_RD;
            ils_pkg::OP_FIND: begin
              state_next = (q_count == '0) ? ils_pkg::BS_REPORT : ils_pkg::BS_SCAN;
            end
            default:            state_next = ils_pkg::BS_REPORT;
          endcase
        end
      end
      ils_pkg::BS_WRITE:   state_next = ils_pkg::BS_REPORT;
      ils_pkg::BS_SHIFT: begin
        if (!pend && dst == pos_a) begin
          state_next = ils_pkg::BS_REPORT;
        end
      end
      ils_pkg::BS_MOVE_RD: state_next = ils_pkg::BS_MOVE_WR;
      ils_pkg::BS_MOVE_WR: state_next = ils_pkg::BS_REPORT;
      ils_pkg::BS_SCAN: begin
        if (cmp_valid && (match || cmp_idx == last_idx)) begin
          state_next = ils_pkg::BS_REPORT;
        end
      end
      ils_pkg::BS_REPORT:  state_next = ils_pkg::BS_IDLE;
      default:             state_next = ils_pkg::BS_IDLE;
    endcase
  end

  // datapath, memory controls and outputs
  always_comb begin
    q_pop          = 1'b0;
    done           = 1'b0;
    mem_we         = 1'b0;
    mem_waddr      = dst;
    mem_wdata      = val_w;
    mem_re         = 1'b0;
    mem_raddr      = dst - AW'(1);
    kind_next      = kind;
    status_r_next  = status_r;
    item_r_next    = item_r;
    cnt_r_next     = cnt_r;
    dst_next       = dst;
    pend_next      = pend;
    pend_dst_next  = pend_dst;
    rd_idx_next    = rd_idx;
    cmp_valid_next = cmp_valid;
    cmp_idx_next   = cmp_idx;
    found_r_next   = found_r;
    fidx_r_next    = fidx_r;
    unique case (state)
      ils_pkg::BS_IDLE: begin
        q_pop          = !q_empty;
        kind_next      = q_ctl.kind;
        status_r_next  = q_ctl.status;
        item_r_next    = q_item;
        cnt_r_next     = q_count;
        dst_next       = AW'(q_count);
        pend_next      = 1'b0;
        rd_idx_next    = '0;
        cmp_valid_next = 1'b0;
        found_r_next   = 1'b0;
        fidx_r_next    = '0;
      end
      ils_pkg::BS_WRITE: begin
        // append at the old end
        mem_we    = 1'b1;
        mem_waddr = AW'(cnt_r);
      end
      ils_pkg::BS_SHIFT: begin
        // read entry dst-1 now, write it to dst in the next cycle
        if (pend) begin
          mem_we    = 1'b1;
          mem_waddr = pend_dst;
          mem_wdata = rd_data;
        end
        if (dst != pos_a) begin
          mem_re        = 1'b1;
          mem_raddr     = dst - AW'(1);
          pend_next     = 1'b1;
          pend_dst_next = dst;
          dst_next      = dst - AW'(1);
        end else begin
          pend_next = 1'b0;
          if (!pend) begin
            mem_we    = 1'b1;
            mem_waddr = pos_a;
          end
        end
      end
      ils_pkg::BS_MOVE_RD: begin
        mem_re    = 1'b1;
        mem_raddr = last_idx;
      end
      ils_pkg::BS_MOVE_WR: begin
        mem_we    = 1'b1;
        mem_waddr = pos_a;
        mem_wdata = rd_data;
      end
      ils_pkg::BS_SCAN: begin
        // read one entry a cycle, compare each entry in the cycle after its read
        if (rd_idx != cnt_r) begin
          mem_re         = 1'b1;
          mem_raddr      = rd_idx[AW-1:0];
          rd_idx_next    = rd_idx + CW'(1);
          cmp_valid_next = 1'b1;
          cmp_idx_next   = rd_idx[AW-1:0];
        end else begin
          cmp_valid_next = 1'b0;
        end
        if (match) begin
          found_r_next = 1'b1;
          fidx_r_next  = cmp_idx;
        end
      end
      ils_pkg::BS_REPORT: begin
        done = 1'b1;
      end
      default: begin
        done = 1'b0;
      end
    endcase
  end

  // count reported with the result
  always_comb begin
    unique case (kind)
      ils_pkg::OP_PUSH, ils_pkg::OP_INSERT: cnt_after = cnt_r + CW'(1);
      ils_pkg::OP_POP, ils_pkg::OP_ERASE:   cnt_after = cnt_r - CW'(1);
      default:                              cnt_after = cnt_r;
    endcase
  end

  assign result.status          = status_r;
  assign result.found           = found_r;
  assign result.found_index     = ils_pkg::POS_W'(fidx_r);
  assign result.entry_count_out = ils_pkg::COUNT_W'(cnt_after);

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ils_pkg::BS_IDLE;
      pend      <= 1'b0;
      cmp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      pend      <= pend_next;
      cmp_valid <= cmp_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    kind     <= kind_next;
    status_r <= status_r_next;
    item_r   <= item_r_next;
    cnt_r    <= cnt_r_next;
    dst      <= dst_next;
    pend_dst <= pend_dst_next;
    rd_idx   <= rd_idx_next;
    cmp_idx  <= cmp_idx_next;
    found_r  <= found_r_next;
    fidx_r   <= fidx_r_next;
  end

  // shift must never read and write the same entry in one cycle
  a_shift_no_overlap: assert property (@(posedge clk) disable iff (rst)
    (state == ils_pkg::BS_SHIFT && mem_we && mem_re) |-> (mem_waddr != mem_raddr))
    else $error("shift read and write collide");

  // scan compares only entries below the count
  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ils_pkg::BS_SCAN && cmp_valid) |-> (CW'(cmp_idx) < cnt_r))
    else $error("scan compared past the count");

  // an append only happens with room in the store
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    (state == ils_pkg::BS_WRITE) |-> (cnt_r < CW'(DEPTH)))
    else $error("append beyond store depth");

  // a result beat is followed by the idle state, never a second beat
  a_single_beat: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result beat repeated");

endmodule

// File: hw/rtl/indexed_list_store.sv
// Steps from accept to the result beat, after the queue: pop, rejected and unused
// commands go straight to the report; push writes first; erase reads the last entry and
// writes it into position; insert shifts up from the end, then writes; find scans to a match.
// Throughput: one command at a time in the back end, whose read and write memory ports move
// one entry per cycle for insert shifts and find scans; a two-beat queue lets start be taken
// while the back end works. The receiver cannot stall; each result is one-cycle done.
// Reset (rst, synchronous): empty list, capacity 1024; store contents are not cleared.
module indexed_list_store #(
  parameter int DEPTH      = ils_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = ils_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  ils_pkg::ils_in_t          item,
  output logic                      busy,
  input  logic                      cfg_we,
  input  logic [ils_pkg::CAP_W-1:0] cfg_wdata,
  output logic                      done,
  output ils_pkg::ils_out_t         result
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int QW = $bits(ils_pkg::op_ctl_t) + $bits(ils_pkg::ils_in_t) + CW;

  logic             q_push;
  logic             q_pop;
  logic             q_full;
  logic             q_empty;
  logic [QW-1:0]    q_wdata;
  logic [QW-1:0]    q_rdata;

  ils_pkg::op_ctl_t f_ctl;
  ils_pkg::ils_in_t f_item;
  logic [CW-1:0]    f_count;

  ils_pkg::op_ctl_t b_ctl;
  ils_pkg::ils_in_t b_item;
  logic [CW-1:0]    b_count;

  ils_front #(
    .DEPTH (DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (item),
    .busy      (busy),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .op_ctl    (f_ctl),
    .op_item   (f_item),
    .op_count  (f_count)
  );

  // pack the classified command for the queue
  assign q_wdata = {f_ctl, f_item, f_count};
  assign {b_ctl, b_item, b_count} = q_rdata;

  ils_queue #(
    .WIDTH (QW)
  ) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  ils_back #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .q_ctl   (b_ctl),
    .q_item  (b_item),
    .q_count (b_count),
    .done    (done),
    .result  (result)
  );

endmodule
